FILE: rtl/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// shared constants for the line rasteriser: field widths, command codes,
// register reset values and the status bundle between the pipeline stages
// ---------------------------------------------------------------------------
package lr_pkg;

    // default coordinate precision inside the block
    localparam int COORD_BITS_DEF = 12;

    // fixed widths of the stream fields
    localparam int FIELD_COORD_W = 12;
    localparam int WIDTH_W       = 13;
    localparam int ADDR_W        = 24;
    localparam int COLOR_W       = 24;

    // packed stream widths
    localparam int S_TDATA_W = 4 * FIELD_COORD_W + COLOR_W;
    localparam int M_TDATA_W = 2 * FIELD_COORD_W + ADDR_W + COLOR_W;

    // image width after reset
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;

    // command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // status of the stepper: point register flags and line busy
    typedef struct packed {
        logic pt_valid;
        logic pt_last;
        logic busy;
    } t_step_stat;

endpackage

FILE: rtl/lr_stepper.sv
// ---------------------------------------------------------------------------
// lr_stepper
// line set-up and per-pixel error update; holds the line state and
// registers one point (x, y, colour, last) per start item or busy step item
// ---------------------------------------------------------------------------
module lr_stepper #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_in_valid,
    input  logic                       i_in_cmd,
    input  logic [COORD_BITS-1:0]      i_x_start,
    input  logic [COORD_BITS-1:0]      i_y_start,
    input  logic [COORD_BITS-1:0]      i_x_end,
    input  logic [COORD_BITS-1:0]      i_y_end,
    input  logic [lr_pkg::COLOR_W-1:0] i_color,
    output logic [COORD_BITS-1:0]      o_pt_x,
    output logic [COORD_BITS-1:0]      o_pt_y,
    output logic [lr_pkg::COLOR_W-1:0] o_pt_color,
    output lr_pkg::t_step_stat         o_stat
);
    import lr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int TW = CB + 1;
    localparam int EW = CB + 3;

    // line state
    logic [CB-1:0]        r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [EW-1:0] r_err;
    logic [TW-1:0]        r_tdx, r_tdy;
    logic [1:0]           r_sx, r_sy;
    logic                 r_x_major;
    logic                 r_busy;
    logic [COLOR_W-1:0]   r_color;

    // point register
    logic [CB-1:0]        r_pt_x, r_pt_y;
    logic                 r_pt_valid, r_pt_last;

    logic [CB-1:0]        n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic signed [EW-1:0] n_err;
    logic [TW-1:0]        n_tdx, n_tdy;
    logic [1:0]           n_sx, n_sy;
    logic                 n_x_major, n_busy, n_pt_valid, n_pt_last;
    logic [COLOR_W-1:0]   n_color;

    // set-up terms
    logic signed [CB:0]   s_dx, s_dy;
    logic [CB:0]          s_adx, s_ady;
    logic [TW-1:0]        s_tdx, s_tdy;
    logic                 s_x_major;

    // step terms
    logic [TW-1:0]        t_maj, t_min;
    logic                 maj_pos, take_minor;
    logic [CB-1:0]        sx_ext, sy_ext, st_x, st_y;
    logic signed [EW-1:0] st_err;

    // line set-up from the endpoints
    always_comb begin
        s_dx      = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
        s_dy      = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
        s_adx     = s_dx[CB] ? (CB+1)'(0) - s_dx : s_dx;
        s_ady     = s_dy[CB] ? (CB+1)'(0) - s_dy : s_dy;
        s_tdx     = {s_adx[CB-1:0], 1'b0};
        s_tdy     = {s_ady[CB-1:0], 1'b0};
        s_x_major = (s_tdx >= s_tdy);
    end

    // one pixel along the major axis
    always_comb begin
        t_maj      = r_x_major ? r_tdx : r_tdy;
        t_min      = r_x_major ? r_tdy : r_tdx;
        maj_pos    = r_x_major ? (r_sx == 2'b01) : (r_sy == 2'b01);
        take_minor = (!r_err[EW-1] && (r_err != '0)) || ((r_err == '0) && maj_pos);
        sx_ext     = {{(CB-2){r_sx[1]}}, r_sx};
        sy_ext     = {{(CB-2){r_sy[1]}}, r_sy};
        st_err     = r_err - (take_minor ? $signed({2'b00, t_maj}) : '0)
                     + $signed({2'b00, t_min});
        st_x       = (r_x_major || take_minor) ? r_cur_x + sx_ext : r_cur_x;
        st_y       = (!r_x_major || take_minor) ? r_cur_y + sy_ext : r_cur_y;
    end

    // next state select
    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_tgt_x    = r_tgt_x;
        n_tgt_y    = r_tgt_y;
        n_err      = r_err;
        n_tdx      = r_tdx;
        n_tdy      = r_tdy;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_x_major  = r_x_major;
        n_busy     = r_busy;
        n_color    = r_color;
        n_pt_valid = 1'b0;
        n_pt_last  = 1'b0;
        if (i_in_valid && (i_in_cmd == CMD_START)) begin
            n_cur_x    = i_x_start;
            n_cur_y    = i_y_start;
            n_tgt_x    = i_x_end;
            n_tgt_y    = i_y_end;
            n_color    = i_color;
            n_tdx      = s_tdx;
            n_tdy      = s_tdy;
            n_sx       = (s_dx == '0) ? 2'b00 : (s_dx[CB] ? 2'b11 : 2'b01);
            n_sy       = (s_dy == '0) ? 2'b00 : (s_dy[CB] ? 2'b11 : 2'b01);
            n_x_major  = s_x_major;
            n_err      = s_x_major
                         ? $signed({2'b00, s_tdy}) - $signed({2'b00, s_adx})
                         : $signed({2'b00, s_tdx}) - $signed({2'b00, s_ady});
            n_pt_last  = s_x_major ? (i_x_start == i_x_end) : (i_y_start == i_y_end);
            n_busy     = !n_pt_last;
            n_pt_valid = 1'b1;
        end else if (i_in_valid && r_busy) begin
            n_cur_x    = st_x;
            n_cur_y    = st_y;
            n_err      = st_err;
            n_pt_last  = r_x_major ? (st_x == r_tgt_x) : (st_y == r_tgt_y);
            n_busy     = !n_pt_last;
            n_pt_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pt_valid <= 1'b0;
        end else if (i_adv) begin
            r_busy     <= n_busy;
            r_pt_valid <= n_pt_valid;
        end
    end

    // line state and point payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_tgt_x   <= n_tgt_x;
            r_tgt_y   <= n_tgt_y;
            r_err     <= n_err;
            r_tdx     <= n_tdx;
            r_tdy     <= n_tdy;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_x_major <= n_x_major;
            r_color   <= n_color;
            r_pt_x    <= n_cur_x;
            r_pt_y    <= n_cur_y;
            r_pt_last <= n_pt_last;
        end
    end

    assign o_pt_x          = r_pt_x;
    assign o_pt_y          = r_pt_y;
    assign o_pt_color      = r_color;
    assign o_stat.pt_valid = r_pt_valid;
    assign o_stat.pt_last  = r_pt_last;
    assign o_stat.busy     = r_busy;

endmodule

FILE: rtl/lr_address.sv
// ---------------------------------------------------------------------------
// lr_address
// framebuffer address y * width + x, wrapped to the address field, and the
// result register that drives the output stream
// ---------------------------------------------------------------------------
module lr_address #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  lr_pkg::t_step_stat               i_stat,
    input  logic [COORD_BITS-1:0]            i_pt_x,
    input  logic [COORD_BITS-1:0]            i_pt_y,
    input  logic [lr_pkg::COLOR_W-1:0]       i_pt_color,
    input  logic [lr_pkg::WIDTH_W-1:0]       i_width,
    output logic                             o_valid,
    output logic                             o_last,
    output logic [lr_pkg::FIELD_COORD_W-1:0] o_x,
    output logic [lr_pkg::FIELD_COORD_W-1:0] o_y,
    output logic [lr_pkg::ADDR_W-1:0]        o_addr,
    output logic [lr_pkg::COLOR_W-1:0]       o_color
);
    import lr_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int PROD_W = CB + WIDTH_W + 1;

    logic [PROD_W-1:0]            prod;
    logic [PROD_W+ADDR_W-1:0]     prod_ext;
    logic [CB+FIELD_COORD_W-1:0]  x_ext, y_ext;

    logic                     r_valid, r_last;
    logic [FIELD_COORD_W-1:0] r_x, r_y;
    logic [ADDR_W-1:0]        r_addr;
    logic [COLOR_W-1:0]       r_color;

    // multiply-add, then fit every value to its field
    always_comb begin
        prod     = PROD_W'(i_pt_y) * PROD_W'(i_width) + PROD_W'(i_pt_x);
        prod_ext = {{ADDR_W{1'b0}}, prod};
        x_ext    = {{FIELD_COORD_W{1'b0}}, i_pt_x};
        y_ext    = {{FIELD_COORD_W{1'b0}}, i_pt_y};
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stat.pt_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_last  <= i_stat.pt_last;
            r_x     <= x_ext[FIELD_COORD_W-1:0];
            r_y     <= y_ext[FIELD_COORD_W-1:0];
            r_addr  <= prod_ext[ADDR_W-1:0];
            r_color <= i_pt_color;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_addr  = r_addr;
    assign o_color = r_color;

endmodule

FILE: rtl/line_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line rasteriser: a start item sets up a line and gives its first
// pixel, each step item during a line gives the next pixel with address and colour
// ---------------------------------------------------------------------------
//  channel   | direction | tdata / data                          | side band
//  s stream  | in        | x_start, y_start, x_end, y_end, color | tuser: cmd
//  m stream  | out       | pixel_x, pixel_y, pixel_address, col. | tlast: last
//  cfg       | in        | image_width (13 bits)                 | -
//
//  one item accepted per cycle while the output is not stalled; its result is
//  offered on the master stream from the address result register, after the
//  stepper point register has held it.
//  the error update and the y * width multiply sit in separate stages.
//  synchronous active-low reset: idle, no line in progress, width 640.
//  a stalled output holds its result while up to two more pixel-giving items
//  are taken; step items with no line in progress flow through while the stepper holds no point.
//  a step item with no line in progress is consumed and gives no result.
// ---------------------------------------------------------------------------
module line_rasterizer_unit #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream: x_start, y_start, x_end, y_end, color (lowest first)
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [lr_pkg::S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic                         i_s_tuser,
    // master stream: pixel_x, pixel_y, pixel_address, pixel_color (lowest first)
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [lr_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                         o_m_tlast,
    // configuration: image_width
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lr_pkg::WIDTH_W-1:0]   i_cfg_data
);
    import lr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int FW = FIELD_COORD_W;

    logic                r_in_valid, r_in_cmd;
    logic [CB-1:0]       r_x0, r_y0, r_x1, r_y1;
    logic [COLOR_W-1:0]  r_in_color;
    logic [WIDTH_W-1:0]  r_width;

    logic                ready_a, ready_b, ready_c;
    t_step_stat          stat;
    logic [CB-1:0]       pt_x, pt_y;
    logic [COLOR_W-1:0]  pt_color;
    logic                out_valid, out_last;
    logic [FW-1:0]       out_x, out_y;
    logic [ADDR_W-1:0]   out_addr;
    logic [COLOR_W-1:0]  out_color;

    logic [CB+FW-1:0]    x0_ext, y0_ext, x1_ext, y1_ext;

    // stage ready chain
    assign ready_c    = !out_valid || i_m_tready;
    assign ready_b    = !stat.pt_valid || ready_c;
    assign ready_a    = !r_in_valid || ready_b;
    assign o_s_tready = ready_a;

    // coordinates to internal precision
    always_comb begin
        x0_ext = {{CB{1'b0}}, i_s_tdata[FW-1:0]};
        y0_ext = {{CB{1'b0}}, i_s_tdata[2*FW-1:FW]};
        x1_ext = {{CB{1'b0}}, i_s_tdata[3*FW-1:2*FW]};
        y1_ext = {{CB{1'b0}}, i_s_tdata[4*FW-1:3*FW]};
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (ready_a) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (ready_a && i_s_tvalid) begin
            r_in_cmd   <= i_s_tuser;
            r_x0       <= x0_ext[CB-1:0];
            r_y0       <= y0_ext[CB-1:0];
            r_x1       <= x1_ext[CB-1:0];
            r_y1       <= y1_ext[CB-1:0];
            r_in_color <= i_s_tdata[4*FW+COLOR_W-1:4*FW];
        end
    end

    // image width register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    lr_stepper #(
        .COORD_BITS (CB)
    ) u_stepper (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (ready_b),
        .i_in_valid (r_in_valid),
        .i_in_cmd   (r_in_cmd),
        .i_x_start  (r_x0),
        .i_y_start  (r_y0),
        .i_x_end    (r_x1),
        .i_y_end    (r_y1),
        .i_color    (r_in_color),
        .o_pt_x     (pt_x),
        .o_pt_y     (pt_y),
        .o_pt_color (pt_color),
        .o_stat     (stat)
    );

    lr_address #(
        .COORD_BITS (CB)
    ) u_address (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (ready_c),
        .i_stat     (stat),
        .i_pt_x     (pt_x),
        .i_pt_y     (pt_y),
        .i_pt_color (pt_color),
        .i_width    (r_width),
        .o_valid    (out_valid),
        .o_last     (out_last),
        .o_x        (out_x),
        .o_y        (out_y),
        .o_addr     (out_addr),
        .o_color    (out_color)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tlast  = out_last;
    assign o_m_tdata  = {out_color, out_addr, out_y, out_x};

`ifndef NO_ASSERTIONS
    // a held point agrees with the line state: busy exactly when not last
    a_busy_vs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pt_valid |-> (stat.busy == !stat.pt_last))
        else $error("busy flag disagrees with last of held point");

    // a start item always gives a point
    a_start_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && ready_b && (r_in_cmd == CMD_START)) |=> stat.pt_valid)
        else $error("start item gave no point");

    // a step with no line in progress gives nothing
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && ready_b && (r_in_cmd == CMD_STEP) && !stat.busy)
        |=> !stat.pt_valid)
        else $error("idle step produced a point");

    // a point moved on reaches the output register
    a_point_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.pt_valid && ready_c) |=> o_m_tvalid)
        else $error("point lost between stepper and output");
`endif

endmodule
